>>> hw/rtl/lfia_pkg.sv
`timescale 1ns / 1ps

package lfia_pkg;

   // Identifier range and widths
   localparam int ID_W      = 8;
   localparam int CNT_W     = 8;
   localparam int STATUS_W  = 2;
   localparam int PID_MIN   = 2;
   localparam int PID_MAX   = 255;
   localparam int ID_FIRST  = PID_MIN - 1;
   localparam int MAP_DEPTH = 1 << ID_W;

   // Two-level search: groups of map bits, then bits within a group
   localparam int GRP_W     = 8;
   localparam int NUM_GRP   = MAP_DEPTH / GRP_W;
   localparam int BIT_IDX_W = $clog2(GRP_W);
   localparam int GRP_IDX_W = ID_W - BIT_IDX_W;

   // Ids below the kernel id are never granted
   localparam logic [MAP_DEPTH-1:0] RESERVED_MASK = (MAP_DEPTH'(1) << ID_FIRST) - MAP_DEPTH'(1);

   // Command codes
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic scan_group;
      logic scan_bit;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic req_release;
   } dp_stat_type;

endpackage

>>> hw/rtl/lfia_if.sv
`timescale 1ns / 1ps

interface lfia_req_if;
   import lfia_pkg::*;

   logic            valid;
   logic            ready;
   logic            cmd;
   logic [ID_W-1:0] release_id;

   modport source (output valid, output cmd, output release_id, input ready);
   modport sink   (input valid, input cmd, input release_id, output ready);
endinterface

interface lfia_rsp_if;
   import lfia_pkg::*;

   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     assigned_id;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    ids_in_use;

   modport source (output valid, output assigned_id, output status, output ids_in_use,
                   input ready);
   modport sink   (input valid, input assigned_id, input status, input ids_in_use,
                   output ready);
endinterface

>>> hw/rtl/lfia_ctrl.sv
`timescale 1ns / 1ps

module lfia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lfia_pkg::dp_stat_type dp_stat,
   output lfia_pkg::ctrl_cmd_type ctrl_cmd
);
   import lfia_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_GROUP  = 4'b0010,
      ST_ENCODE = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_xfer;
   logic      rsp_xfer;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequence one command through search and commit
   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl_cmd.load_req = req_xfer;
            if (req_xfer) begin
               state_in = dp_stat.req_release ? ST_COMMIT : ST_GROUP;
            end
         end
         ST_GROUP: begin
            ctrl_cmd.scan_group = 1'b1;
            state_in = ST_ENCODE;
         end
         ST_ENCODE: begin
            ctrl_cmd.scan_bit = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Hold until the result register can take the new result
            if (slot_free) begin
               ctrl_cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Track the pending result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/lfia_dp.sv
`timescale 1ns / 1ps

module lfia_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_cmd,
   input  logic [lfia_pkg::ID_W-1:0]      req_release_id,
   input  lfia_pkg::ctrl_cmd_type         ctrl_cmd,
   output lfia_pkg::dp_stat_type          dp_stat,
   output logic [lfia_pkg::ID_W-1:0]      assigned_id,
   output logic [lfia_pkg::STATUS_W-1:0]  status,
   output logic [lfia_pkg::CNT_W-1:0]     ids_in_use
);
   import lfia_pkg::*;

   logic [MAP_DEPTH-1:0] map_ff, map_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 cmd_ff;
   logic [ID_W-1:0]      rid_ff;
   logic [NUM_GRP-1:0]   grp_free_ff, grp_free_in;
   logic [GRP_IDX_W-1:0] grp_idx_ff, grp_idx_in;
   logic                 any_free_ff;
   logic [ID_W-1:0]      assigned_ff, assigned_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic [MAP_DEPTH-1:0] map_eff;
   logic [GRP_W-1:0]     grp_bits;
   logic [BIT_IDX_W-1:0] bit_idx;
   logic [ID_W-1:0]      new_id;
   logic                 bad_release;

   assign dp_stat.req_release = (req_cmd == CMD_RELEASE);
   assign assigned_id = assigned_ff;
   assign status      = status_ff;
   assign ids_in_use  = count_ff;

   // Treat ids below the kernel id as always taken
   assign map_eff = map_ff | RESERVED_MASK;

   // Flag groups that still hold a free id
   always_comb begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_free_in[g] = ~&map_eff[g*GRP_W +: GRP_W];
      end
   end

   // Pick the lowest group with a free id
   always_comb begin
      grp_idx_in = '0;
      for (int g = NUM_GRP - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) begin
            grp_idx_in = GRP_IDX_W'(g);
         end
      end
   end

   // Pick the lowest free bit inside the chosen group
   always_comb begin
      grp_bits = map_eff[grp_idx_ff*GRP_W +: GRP_W];
      bit_idx  = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
         if (!grp_bits[b]) begin
            bit_idx = BIT_IDX_W'(b);
         end
      end
   end

   assign new_id = {grp_idx_ff, bit_idx};

   assign bad_release = (rid_ff < ID_W'(PID_MIN)) ||
                        ((ID_W+1)'(rid_ff) > (ID_W+1)'(PID_MAX)) ||
                        !map_ff[ID_FIRST];

   // Apply the command to the map and count, build the result
   always_comb begin
      map_in      = map_ff;
      count_in    = count_ff;
      assigned_in = '0;
      status_in   = STATUS_OK;
      if (cmd_ff == CMD_ALLOC) begin
         if (any_free_ff) begin
            map_in[new_id] = 1'b1;
            count_in       = count_ff + CNT_W'(1);
            assigned_in    = new_id;
         end else begin
            status_in = STATUS_FULL;
         end
      end else begin
         if (bad_release) begin
            status_in = STATUS_RANGE;
         end else if (!map_ff[rid_ff]) begin
            status_in = STATUS_NOT_FOUND;
         end else begin
            map_in[rid_ff] = 1'b0;
            count_in       = count_ff - CNT_W'(1);
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff   <= '0;
         count_ff <= '0;
      end else if (ctrl_cmd.commit) begin
         map_ff   <= map_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load_req) begin
         cmd_ff <= req_cmd;
         rid_ff <= req_release_id;
      end
      if (ctrl_cmd.scan_group) begin
         grp_free_ff <= grp_free_in;
      end
      if (ctrl_cmd.scan_bit) begin
         grp_idx_ff  <= grp_idx_in;
         any_free_ff <= |grp_free_ff;
      end
      if (ctrl_cmd.commit) begin
         assigned_ff <= assigned_in;
         status_ff   <= status_in;
      end
   end

endmodule

>>> hw/rtl/lowest_free_id_allocator.sv
`timescale 1ns / 1ps
// Allocate: after the request transfer, group scan, encode and commit; the result is registered at commit.
// Release: after the request transfer, commit only; the result is registered at commit.
// One command in flight; next request taken the cycle after the previous one commits;
// a result that is not taken holds the commit and with it the next request.
// Synchronous reset clears the used map, the in-use count and all handshake state.

module lowest_free_id_allocator (
   input logic         clock,
   input logic         reset,
   lfia_req_if.sink    req_chan,
   lfia_rsp_if.source  rsp_chan
);
   import lfia_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   lfia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_stat   (dp_stat),
      .ctrl_cmd  (ctrl_cmd)
   );

   lfia_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_chan.cmd),
      .req_release_id (req_chan.release_id),
      .ctrl_cmd       (ctrl_cmd),
      .dp_stat        (dp_stat),
      .assigned_id    (rsp_chan.assigned_id),
      .status         (rsp_chan.status),
      .ids_in_use     (rsp_chan.ids_in_use)
   );

endmodule
